### src/assert_macros.svh
// Shared concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of ck while rst_n is high.
`define ASSERT_CLK(label, ck, rst_n, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising edge of ck, reset included.
`define ASSERT_ALWAYS(label, ck, prop, msg) \
	label: assert property (@(posedge ck) prop) else $error(msg);

`endif

### src/mbps_pkg.sv
package mbps_pkg;

	localparam int unsigned PAT_BYTES   = 8;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned BYTE_IDX_W  = 3;
	localparam int unsigned LEN_W       = 4;
	localparam int unsigned ADDR_W      = 64;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned CFG_W       = 64;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned MAX_PATTERN = 8;

	typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_t;
	typedef logic [PAT_BYTES-1:0]             care_t;
	typedef logic [LEN_W-1:0]                 len_t;
	typedef logic [BYTE_W-1:0]                byte_t;
	typedef logic [ADDR_W-1:0]                addr_t;
	typedef logic [COUNT_W-1:0]               count_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN = 2'd0,
		REG_CARE    = 2'd1,
		REG_LENGTH  = 2'd2,
		REG_BASE    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic  found;
		addr_t match_address;
	} result_t;

	localparam care_t CARE_RESET = '1;
	localparam len_t  LEN_RESET  = len_t'(1);

endpackage

### src/mbps_if.sv
interface mbps_byte_if;
	logic                 valid;
	logic                 ready;
	mbps_pkg::byte_t      data_byte;
	logic                 last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_result_if;
	logic                 valid;
	logic                 ready;
	logic                 found;
	mbps_pkg::addr_t      match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

### src/mbps_cell.sv
module mbps_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic            clk,
	input  logic            shift,
	input  mbps_pkg::byte_t byte_in,
	input  mbps_pkg::pat_t  pattern,
	input  mbps_pkg::care_t care,
	input  mbps_pkg::len_t  eff_len,
	output mbps_pkg::byte_t byte_q,
	output logic            hit
);

	mbps_pkg::len_t                     k;
	logic [mbps_pkg::BYTE_IDX_W-1:0]    sel;
	logic                               used;

	always_comb begin
		k    = eff_len - mbps_pkg::len_t'(1) - mbps_pkg::len_t'(IDX);
		sel  = k[mbps_pkg::BYTE_IDX_W-1:0];
		used = mbps_pkg::len_t'(IDX) < eff_len;
		hit  = !used || !care[sel] || (byte_in == pattern[sel]);
	end

	// hand the byte on to the next cell
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

### src/mbps_outbuf.sv
module mbps_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mbps_pkg::result_t push_data,
	output logic              full,
	mbps_result_if.source     result_ch
);

	mbps_pkg::result_t head_q, tail_q;
	logic              head_valid_q, tail_valid_q;
	logic              pop;

	assign pop                     = head_valid_q && result_ch.ready;
	assign full                    = tail_valid_q;
	assign result_ch.valid         = head_valid_q;
	assign result_ch.found         = head_q.found;
	assign result_ch.match_address = head_q.match_address;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			tail_valid_q <= 1'b0;
		end else begin
			unique case ({push, pop})
				2'b11: begin
					if (!tail_valid_q) begin
						head_valid_q <= 1'b1;
					end
				end
				2'b10: begin
					if (head_valid_q) begin
						tail_valid_q <= 1'b1;
					end else begin
						head_valid_q <= 1'b1;
					end
				end
				2'b01: begin
					head_valid_q <= tail_valid_q;
					tail_valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b11: begin
				if (tail_valid_q) begin
					head_q <= tail_q;
					tail_q <= push_data;
				end else begin
					head_q <= push_data;
				end
			end
			2'b10: begin
				if (head_valid_q) begin
					tail_q <= push_data;
				end else begin
					head_q <= push_data;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			default: begin
			end
		endcase
	end

endmodule

### src/masked_byte_pattern_search_top.sv
// Masked byte pattern search: takes one word (a byte and an end-of-region flag) per clock and
// compares the newest bytes against a pattern of up to eight bytes, with a care bit per byte,
// in a chain of one compare cell per pattern byte. The first full match inside a region gives
// one result (found = 1, base register plus the match start offset), which is pushed into the
// output buffer as the byte that completes it is accepted; a region with no match gives one
// not-found result after its last byte. Throughput is one byte per clock; results wait in a
// two-entry output buffer, and input stalls only while that buffer holds two results. Write the
// configuration registers only while the block is idle.
`include "assert_macros.svh"

module masked_byte_pattern_search_top #(
	parameter int unsigned MAX_PATTERN = mbps_pkg::MAX_PATTERN
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbps_pkg::CFG_W-1:0]        cfg_data,
	mbps_byte_if.sink                         byte_ch,
	mbps_result_if.source                     result_ch
);

	mbps_pkg::pat_t    pattern_q;
	mbps_pkg::care_t   care_q;
	mbps_pkg::len_t    length_q;
	mbps_pkg::addr_t   base_q;
	mbps_pkg::count_t  seen_q;
	logic              reported_q;

	mbps_pkg::len_t    eff_len;
	mbps_pkg::count_t  seen_nx;
	mbps_pkg::count_t  offset;
	logic              accept;
	logic              match_now;
	logic              push;
	logic              full;
	mbps_pkg::result_t res;

	mbps_pkg::byte_t          window [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]   hits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			care_q    <= mbps_pkg::CARE_RESET;
			length_q  <= mbps_pkg::LEN_RESET;
			base_q    <= '0;
		end else if (cfg_we) begin
			unique case (mbps_pkg::cfg_reg_t'(cfg_index))
				mbps_pkg::REG_PATTERN: pattern_q <= cfg_data;
				mbps_pkg::REG_CARE:    care_q    <= cfg_data[mbps_pkg::PAT_BYTES-1:0];
				mbps_pkg::REG_LENGTH:  length_q  <= cfg_data[mbps_pkg::LEN_W-1:0];
				mbps_pkg::REG_BASE:    base_q    <= cfg_data[mbps_pkg::ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (length_q == '0) begin
			eff_len = mbps_pkg::len_t'(1);
		end else if (length_q > mbps_pkg::len_t'(MAX_PATTERN)) begin
			eff_len = mbps_pkg::len_t'(MAX_PATTERN);
		end else begin
			eff_len = length_q;
		end
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		mbps_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.shift  (accept),
			.byte_in((i == 0) ? byte_ch.data_byte : window[(i == 0) ? 0 : i - 1]),
			.pattern(pattern_q),
			.care   (care_q),
			.eff_len(eff_len),
			.byte_q (window[i]),
			.hit    (hits[i])
		);
	end

	assign byte_ch.ready = !full;
	assign accept        = byte_ch.valid && byte_ch.ready;

	always_comb begin
		seen_nx   = (&seen_q) ? seen_q : seen_q + mbps_pkg::count_t'(1);
		offset    = seen_nx - mbps_pkg::count_t'(eff_len);
		match_now = !reported_q && (seen_nx >= mbps_pkg::count_t'(eff_len)) && (&hits);
		push      = accept && (match_now || (!reported_q && byte_ch.last_byte));
		res.found = match_now;
		res.match_address = match_now ? base_q + mbps_pkg::addr_t'(offset) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (byte_ch.last_byte) begin
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else begin
				seen_q     <= seen_nx;
				reported_q <= reported_q || match_now;
			end
		end
	end

	mbps_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(res),
		.full     (full),
		.result_ch(result_ch)
	);

	`ASSERT_CLK(a_one_result, clk, arst_n, (accept && reported_q) |-> !push, "second result in region")
	`ASSERT_CLK(a_region_end, clk, arst_n, (accept && byte_ch.last_byte) |=> (seen_q == '0 && !reported_q), "region state not cleared")
	`ASSERT_CLK(a_mark_match, clk, arst_n, (accept && match_now && !byte_ch.last_byte) |=> reported_q, "match not recorded")

endmodule

### verif/match_report_checker.sv
`timescale 1ns / 1ps

module match_report_checker
	import mbps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	mbps_byte_if                 byte_ch,
	mbps_result_if               result_ch,
	output int                   mismatches,
	output int                   pending
);

	pat_t    cur_pattern;
	care_t   cur_care;
	len_t    cur_length;
	addr_t   cur_base;
	byte_t   window [MAX_PATTERN];
	count_t  bytes_seen;
	logic    match_reported;
	result_t expected_reports [$];

	function automatic void start_region();
		foreach (window[i])
			window[i] = '0;
		bytes_seen     = '0;
		match_reported = 1'b0;
	endfunction

	// Shift one word into the window; return 1 when it produces a report.
	function automatic logic scan_byte(input byte_t value, input logic is_last,
			output result_t report);
		int unsigned len;
		int          k;
		logic        hit;
		logic        emit;
		len = cur_length;
		if (len < 1)
			len = 1;
		if (len > MAX_PATTERN)
			len = MAX_PATTERN;
		for (k = MAX_PATTERN - 1; k > 0; k--)
			window[k] = window[k - 1];
		window[0] = value;
		if (bytes_seen != '1)
			bytes_seen++;
		hit = (bytes_seen >= count_t'(len));
		for (k = 0; k < len; k++)
			if (cur_care[k] && window[len - 1 - k] != cur_pattern[k])
				hit = 1'b0;
		emit   = 1'b0;
		report = '0;
		if (!match_reported) begin
			if (hit) begin
				report.found         = 1'b1;
				report.match_address = cur_base + addr_t'(bytes_seen - count_t'(len));
				match_reported       = 1'b1;
				emit                 = 1'b1;
			end else if (is_last) begin
				emit = 1'b1;
			end
		end
		if (is_last)
			start_region();
		return emit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t report;
		result_t got;
		result_t want;
		if (!arst_n) begin
			cur_pattern = '0;
			cur_care    = CARE_RESET;
			cur_length  = LEN_RESET;
			cur_base    = '0;
			start_region();
			expected_reports.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN: cur_pattern = cfg_data;
					REG_CARE:    cur_care = cfg_data[PAT_BYTES-1:0];
					REG_LENGTH:  cur_length = cfg_data[LEN_W-1:0];
					REG_BASE:    cur_base = cfg_data;
					default: ;
				endcase
			end
			if (byte_ch.valid && byte_ch.ready) begin
				if (scan_byte(byte_ch.data_byte, byte_ch.last_byte, report))
					expected_reports.push_back(report);
			end
			if (result_ch.valid && result_ch.ready) begin
				got.found         = result_ch.found;
				got.match_address = result_ch.match_address;
				if (expected_reports.size() == 0) begin
					mismatches++;
					$error("unexpected word: found %0b match_address %h",
						got.found, got.match_address);
				end else begin
					want = expected_reports.pop_front();
					if (got.found !== want.found) begin
						mismatches++;
						$error("found: expected %0b, actual %0b", want.found, got.found);
					end
					if (got.match_address !== want.match_address) begin
						mismatches++;
						$error("match_address: expected %h, actual %h",
							want.match_address, got.match_address);
					end
				end
			end
			pending <= expected_reports.size();
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mbps_pkg::*;

	localparam int ITEM_TARGET = 1550;
	localparam int HOLD_CYCLES = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   mismatches;
	int                   pending;
	int                   byte_gap_max = 8;
	int                   reply_gap_max = 8;
	int                   items_sent;
	bit                   hold_request;

	mbps_byte_if   byte_ch ();
	mbps_result_if result_ch ();

	masked_byte_pattern_search_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	match_report_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_ch    (byte_ch),
		.result_ch  (result_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_byte(input byte_t value, input logic is_last);
		int gap;
		gap = $urandom_range(0, byte_gap_max);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= value;
		byte_ch.last_byte <= is_last;
		do @(posedge clk); while (!byte_ch.ready);
		items_sent++;
	endtask

	task automatic settle();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	function automatic byte_t noise_byte(input logic [CFG_W-1:0] pattern);
		int pick;
		pick = $urandom_range(0, PAT_BYTES - 1);
		if ($urandom_range(0, 1) != 0)
			return pattern[8 * pick +: 8];
		return byte_t'($urandom);
	endfunction

	initial begin
		int wait_cycles;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			wait_cycles = $urandom_range(0, reply_gap_max);
			if (wait_cycles != 0) begin
				result_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	initial begin
		logic [CFG_W-1:0] pat_value;
		care_t            care_bits;
		len_t             len_value;
		int               eff_len;
		int               kind;
		int               keep;
		int               k;
		byte_t            region_bytes [$];
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_PATTERN;
		cfg_data          <= '0;
		byte_ch.valid     <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.last_byte <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);

		settle();
		write_reg(REG_PATTERN, 64'hFFEE_DDCC_BBAA_9988);
		write_reg(REG_CARE, 64'hFF);
		write_reg(REG_LENGTH, 64'hF);
		write_reg(REG_BASE, '1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h88, 1'b0);
		for (k = 0; k < 8; k++)
			send_byte(8'h88 + 8'(8'h11 * k), k == 7);

		settle();
		write_reg(REG_PATTERN, '1);
		write_reg(REG_CARE, '0);
		write_reg(REG_LENGTH, '0);
		write_reg(REG_BASE, 64'h8000_0000_0000_0000);
		send_byte(8'h5A, 1'b1);

		settle();
		write_reg(REG_PATTERN, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_CARE, 64'hFD);
		write_reg(REG_LENGTH, 64'd3);
		write_reg(REG_BASE, '0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hAB, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'hAB, 1'b1);

		// hold the result side while one-word regions keep coming
		settle();
		write_reg(REG_PATTERN, '0);
		write_reg(REG_CARE, '0);
		write_reg(REG_LENGTH, 64'd1);
		write_reg(REG_BASE, '0);
		byte_gap_max = 0;
		hold_request = 1'b1;
		repeat (40) send_byte(byte_t'($urandom), 1'b1);

		while (items_sent < ITEM_TARGET) begin
			settle();
			case ($urandom_range(0, 5))
				0: pat_value = '0;
				1: pat_value = '1;
				default: pat_value = {$urandom, $urandom};
			endcase
			case ($urandom_range(0, 3))
				0: care_bits = '1;
				1: care_bits = '0;
				default: care_bits = care_t'($urandom);
			endcase
			if ($urandom_range(0, 9) == 0)
				len_value = ($urandom_range(0, 1) != 0) ? len_t'(0) : len_t'($urandom_range(9, 15));
			else
				len_value = len_t'($urandom_range(1, MAX_PATTERN));
			eff_len = len_value;
			if (eff_len < 1)
				eff_len = 1;
			if (eff_len > MAX_PATTERN)
				eff_len = MAX_PATTERN;
			write_reg(REG_PATTERN, pat_value);
			write_reg(REG_CARE, {$urandom, 24'($urandom), care_bits});
			write_reg(REG_LENGTH, {$urandom, 28'($urandom), len_value});
			case ($urandom_range(0, 5))
				0: write_reg(REG_BASE, '0);
				1: write_reg(REG_BASE, '1);
				default: write_reg(REG_BASE, {$urandom, $urandom});
			endcase
			byte_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
			reply_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;

			repeat ($urandom_range(1, 6)) begin
				region_bytes.delete();
				// mostly full matches, then cut-short matches, then plain noise
				kind = $urandom_range(0, 7);
				keep = (kind < 6) ? eff_len : (kind == 6) ? $urandom_range(0, eff_len - 1) : 0;
				repeat ($urandom_range(0, 10)) region_bytes.push_back(noise_byte(pat_value));
				for (k = 0; k < keep; k++)
					region_bytes.push_back(care_bits[k] ? pat_value[8 * k +: 8] : byte_t'($urandom));
				if (kind < 6)
					repeat ($urandom_range(0, 5)) region_bytes.push_back(noise_byte(pat_value));
				if (region_bytes.size() == 0)
					region_bytes.push_back(noise_byte(pat_value));
				foreach (region_bytes[j])
					send_byte(region_bytes[j], j == region_bytes.size() - 1);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### masked_byte_pattern_search_top.f
+incdir+src
src/mbps_pkg.sv
src/mbps_if.sv
src/mbps_cell.sv
src/mbps_outbuf.sv
src/masked_byte_pattern_search_top.sv
verif/match_report_checker.sv
verif/tb_top.sv
